[rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants, types and helpers for the multi-width circular byte FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int STORE_BYTES = 256;
  localparam int NUM_BANKS   = 4;
  localparam int PTR_W       = $clog2(STORE_BYTES);
  localparam int FREE_W      = $clog2(STORE_BYTES + 1);
  localparam int BANK_DEPTH  = STORE_BYTES / NUM_BANKS;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int LANE_W      = $clog2(NUM_BANKS);

  localparam logic [FREE_W-1:0] STORE_FREE = FREE_W'(STORE_BYTES);
  localparam logic [PTR_W:0]    STORE_POS  = (PTR_W + 1)'(STORE_BYTES);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         wdata;
  } bank_req_t;

  // byte count of a size code; zero for the unused code
  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      SZ_BYTE: n = 3'd1;
      SZ_HALF: n = 3'd2;
      SZ_WORD: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // position arithmetic modulo the store size
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W:0]   off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + off;
    if (s >= STORE_POS) begin
      s = s - STORE_POS;
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

[rtl/brf_if.sv]
// ----------------------------------------------------------------------------
// brf_in_if / brf_out_if
// Valid/ready channels carrying operation beats and result beats.
// ----------------------------------------------------------------------------
interface brf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  size_code;
  logic [31:0] push_value;

  modport source (output valid, command, size_code, push_value, input ready);
  modport sink   (input valid, command, size_code, push_value, output ready);
endinterface

interface brf_out_if import brf_pkg::*;;
  logic              valid;
  logic              ready;
  logic              success;
  logic [31:0]       pop_value;
  logic [FREE_W-1:0] free_bytes;

  modport source (output valid, success, pop_value, free_bytes, input ready);
  modport sink   (input valid, success, pop_value, free_bytes, output ready);
endinterface

[rtl/byte_ring_fifo_multiwidth.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_multiwidth
// Circular byte FIFO with 1, 2 and 4 byte push and pop beats, little endian.
// ----------------------------------------------------------------------------
// Accepts one operation beat per cycle unless the result path stalls, and
// returns one result beat for each via the bank read, stage-one and
// result registers. The 256-byte store is split into four byte-wide banks of 64
// entries, interleaved on the low two position bits, so any 1, 2 or 4 byte
// access touches each bank at most once. Writes land in the cycle of
// acceptance, so a pop right after a push sees its bytes. Reset empties the
// queue at once; the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_multiwidth import brf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch
);

  bank_req_t  bank_req   [NUM_BANKS];
  logic [7:0] bank_rdata [NUM_BANKS];

  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .bank_req   (bank_req),
    .bank_rdata (bank_rdata)
  );

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    brf_bank u_bank (
      .clk   (clk),
      .req   (bank_req[g]),
      .rdata (bank_rdata[g])
    );
  end

endmodule

[rtl/brf_bank.sv]
// ----------------------------------------------------------------------------
// brf_bank
// One byte-wide bank of the store: synchronous write, registered read.
// ----------------------------------------------------------------------------
module brf_bank import brf_pkg::*; (
  input  logic       clk,
  input  bank_req_t  req,
  output logic [7:0] rdata
);

  logic [7:0] mem [BANK_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl
// Pointer and free-count tracking, bank request generation, pop assembly
// and the result register.
// ----------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  brf_in_if.sink     in_ch,
  brf_out_if.source  out_ch,
  output bank_req_t  bank_req   [NUM_BANKS],
  input  logic [7:0] bank_rdata [NUM_BANKS]
);

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;

  logic              s1_valid_r;
  logic              s1_ok_r;
  logic              s1_pop_r;
  logic [LANE_W-1:0] s1_rot_r;
  logic [2:0]        s1_n_r;
  logic [FREE_W-1:0] s1_free_r;

  logic              out_valid_r;
  logic              out_success_r;
  logic [31:0]       out_value_r;
  logic [FREE_W-1:0] out_free_r;

  logic              accept, s1_adv, is_pop, ok;
  logic [2:0]        n;
  logic [FREE_W-1:0] n_ext, used;
  logic [PTR_W-1:0]  base, base_nxt;
  logic [31:0]       pop_word;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    n        = size_bytes(in_ch.size_code);
    n_ext    = FREE_W'(n);
    used     = STORE_FREE - free_r;
    is_pop   = (in_ch.command == CMD_POP);
    ok       = (n != 3'd0) && (is_pop ? (used >= n_ext) : (free_r >= n_ext));
    base     = is_pop ? rd_ptr_r : wr_ptr_r;
    base_nxt = wrap_add(base, (PTR_W + 1)'(n));

    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    free_nxt   = free_r;
    if (ok) begin
      if (is_pop) begin
        rd_ptr_nxt = base_nxt;
        free_nxt   = free_r + n_ext;
      end else begin
        wr_ptr_nxt = base_nxt;
        free_nxt   = free_r - n_ext;
      end
    end
  end

  // byte lane i of the beat lives in bank (base + i) mod 4
  always_comb begin
    logic [LANE_W-1:0] lane;
    logic              hit;
    for (int b = 0; b < NUM_BANKS; b++) begin
      lane = LANE_W'(b) - base[LANE_W-1:0];
      hit  = accept && ok && ({1'b0, lane} < n);
      bank_req[b].wr_en = hit && !is_pop;
      bank_req[b].rd_en = hit && is_pop;
      bank_req[b].addr  = BANK_AW'(wrap_add(base, (PTR_W + 1)'(lane)) >> LANE_W);
      bank_req[b].wdata = in_ch.push_value[8*lane +: 8];
    end
  end

  always_comb begin
    logic [LANE_W-1:0] bsel;
    for (int i = 0; i < NUM_BANKS; i++) begin
      bsel = s1_rot_r + LANE_W'(i);
      pop_word[8*i +: 8] = (s1_ok_r && s1_pop_r && (3'(i) < s1_n_r)) ?
                           bank_rdata[bsel] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      free_r      <= STORE_FREE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        rd_ptr_r <= rd_ptr_nxt;
        wr_ptr_r <= wr_ptr_nxt;
        free_r   <= free_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r   <= ok;
      s1_pop_r  <= is_pop;
      s1_rot_r  <= base[LANE_W-1:0];
      s1_n_r    <= n;
      s1_free_r <= free_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_success_r <= s1_ok_r;
      out_value_r   <= pop_word;
      out_free_r    <= s1_free_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.success    = out_success_r;
  assign out_ch.pop_value  = out_value_r;
  assign out_ch.free_bytes = out_free_r;

endmodule

[rtl/brf_checker.sv]
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks on result beats of the byte FIFO.
// ----------------------------------------------------------------------------
module brf_checker import brf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_success,
  input logic [31:0]       out_pop_value,
  input logic [FREE_W-1:0] out_free_bytes
);

  logic [FREE_W-1:0] last_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_free_r <= STORE_FREE;
    end else if (out_valid && out_ready) begin
      last_free_r <= out_free_bytes;
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_bytes <= STORE_FREE)
    else $error("free count beyond store size");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_pop_value == 32'd0)
    else $error("failed beat carries data");

  a_fail_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_free_bytes == last_free_r)
    else $error("failed beat changed free count");

  a_ok_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_free_bytes != last_free_r)
    else $error("successful beat left free count unchanged");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pop_value)
      && $stable(out_free_bytes) && $stable(out_success))
    else $error("stalled result beat changed");

endmodule

bind byte_ring_fifo_multiwidth brf_checker u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_success    (out_ch.success),
  .out_pop_value  (out_ch.pop_value),
  .out_free_bytes (out_ch.free_bytes)
);

[dv/byte_ring_fifo_multiwidth_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_multiwidth_tb
// Self-checking bench for the multi-width circular byte FIFO. Operation beats
// go in through the input channel, and a scoreboard predicts every result
// beat from its own copy of the ring. Directed checks cover the empty queue,
// the unused size code and value extremes. Random traffic then alternates
// fill-heavy and drain-heavy phases to hit full, empty and wrap-around.
// ----------------------------------------------------------------------------
module byte_ring_fifo_multiwidth_tb;
  import brf_pkg::*;

  localparam logic [1:0] SZ_UNUSED = 2'd3;

  typedef struct packed {
    logic              success;
    logic [31:0]       pop_value;
    logic [FREE_W-1:0] free_bytes;
  } op_result_t;

  logic clk = 1'b0;
  logic rst_n;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();

  byte_ring_fifo_multiwidth dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scoreboard copy of the ring
  logic [7:0]        ring_bytes [STORE_BYTES];
  logic [PTR_W-1:0]  head_pos;
  logic [PTR_W-1:0]  tail_pos;
  logic [FREE_W-1:0] free_left;
  op_result_t        pending_results [$];
  int                mismatch_count;
  bit                quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 9);
  end

  function automatic op_result_t fifo_apply(input logic cmd, input logic [1:0] code,
                                            input logic [31:0] value);
    op_result_t r;
    int         n;
    int         stored;
    r = '0;
    case (code)
      SZ_BYTE: n = 1;
      SZ_HALF: n = 2;
      SZ_WORD: n = 4;
      default: n = 0;
    endcase
    stored = STORE_BYTES - int'(free_left);
    if (n != 0) begin
      if (cmd == CMD_PUSH) begin
        if (int'(free_left) >= n) begin
          for (int i = 0; i < n; i++) begin
            ring_bytes[(int'(tail_pos) + i) % STORE_BYTES] = value[8*i +: 8];
          end
          tail_pos  = PTR_W'((int'(tail_pos) + n) % STORE_BYTES);
          free_left = free_left - FREE_W'(n);
          r.success = 1'b1;
        end
      end else if (stored >= n) begin
        for (int i = 0; i < n; i++) begin
          r.pop_value[8*i +: 8] = ring_bytes[(int'(head_pos) + i) % STORE_BYTES];
        end
        head_pos  = PTR_W'((int'(head_pos) + n) % STORE_BYTES);
        free_left = free_left + FREE_W'(n);
        r.success = 1'b1;
      end
    end
    r.free_bytes = free_left;
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_op(input logic cmd, input logic [1:0] code, input logic [31:0] value);
    while (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.size_code  <= code;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(fifo_apply(cmd, code, value));
  endtask

  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.success, out_ch.pop_value, out_ch.free_bytes};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: success=%0b pop_value=%08h free_bytes=%0d",
                   got.success, got.pop_value, got.free_bytes);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected success=%0b pop_value=%08h free_bytes=%0d",
                     want.success, want.pop_value, want.free_bytes);
            $display("          actual   success=%0b pop_value=%08h free_bytes=%0d",
                     got.success, got.pop_value, got.free_bytes);
          end
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_op(CMD_POP,  SZ_BYTE,   32'h0000_0000);
    send_op(CMD_POP,  SZ_HALF,   32'hFFFF_FFFF);
    send_op(CMD_POP,  SZ_WORD,   32'h0000_0000);
    send_op(CMD_POP,  SZ_UNUSED, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, SZ_UNUSED, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, SZ_BYTE,   32'h0000_00FF);
    // short queue: one byte stored
    send_op(CMD_POP,  SZ_HALF,   32'h0000_0000);
    send_op(CMD_POP,  SZ_WORD,   32'h0000_0000);
    send_op(CMD_POP,  SZ_BYTE,   32'h0000_0000);
  endtask

  task automatic test_value_extremes();
    send_op(CMD_PUSH, SZ_WORD, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, SZ_WORD, 32'h0000_0000);
    send_op(CMD_PUSH, SZ_HALF, 32'h1234_A5C3);
    send_op(CMD_PUSH, SZ_BYTE, 32'hFFFF_FF80);
    send_op(CMD_PUSH, SZ_WORD, 32'h8000_0001);
    send_op(CMD_POP,  SZ_BYTE, 32'hFFFF_FFFF);
    send_op(CMD_POP,  SZ_HALF, 32'h0000_0000);
    send_op(CMD_POP,  SZ_WORD, 32'h0000_0000);
    send_op(CMD_POP,  SZ_WORD, 32'h0000_0000);
    send_op(CMD_POP,  SZ_HALF, 32'h0000_0000);
    send_op(CMD_POP,  SZ_HALF, 32'h0000_0000);
    send_op(CMD_POP,  SZ_BYTE, 32'h0000_0000);
  endtask

  // fill-heavy and drain-heavy phases push the ring to full and empty and
  // move the pointers around the wrap point many times
  task automatic test_random_traffic();
    int         push_pct [8] = '{85, 15, 90, 10, 85, 15, 50, 50};
    logic       cmd;
    logic [1:0] code;
    for (int p = 0; p < 8; p++) begin
      quiet = (p == 3) || (p == 4);
      for (int k = 0; k < 180; k++) begin
        cmd  = ($urandom_range(99) < push_pct[p]) ? CMD_PUSH : CMD_POP;
        code = ($urandom_range(19) == 0) ? SZ_UNUSED : 2'($urandom_range(2));
        send_op(cmd, code, $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    quiet            = 1'b0;
    mismatch_count   = 0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_PUSH;
    in_ch.size_code  = SZ_BYTE;
    in_ch.push_value = 32'h0;
    out_ch.ready     = 1'b0;
    head_pos         = '0;
    tail_pos         = '0;
    free_left        = STORE_FREE;
    for (int i = 0; i < STORE_BYTES; i++) begin
      ring_bytes[i] = 8'h00;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_value_extremes();
    test_random_traffic();
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/brf_pkg.sv
rtl/brf_if.sv
rtl/brf_bank.sv
rtl/brf_ctrl.sv
rtl/byte_ring_fifo_multiwidth.sv
rtl/brf_checker.sv
dv/byte_ring_fifo_multiwidth_tb.sv
